// ===== hw/rtl/ascii_art_pixel_mapper_with_code_embed_defines.svh =====
// Assertion macros used by the pixel mapper datapath RTL
`ifndef ASCII_ART_PIXEL_MAPPER_WITH_CODE_EMBED_DEFINES_SVH
`define ASCII_ART_PIXEL_MAPPER_WITH_CODE_EMBED_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define AAPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define AAPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/aapm_pkg.sv =====
// Types, constants and lookup functions for the ASCII-art pixel mapper
package aapm_pkg;

  localparam int CODE_DEPTH_DEF = 4096;
  localparam int MAX_WIDTH_DEF  = 4096;

  localparam int IMAGE_WIDTH_W = 13;
  localparam int LUMA_MODE_W   = 2;
  localparam int VAL_W         = 32;
  localparam int NUM_LIMITS    = 11;

  // Input function codes
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_PIXEL  = 2'd2;

  // Brightness modes
  localparam logic [1:0] MODE_BT601 = 2'd0;
  localparam logic [1:0] MODE_BT709 = 2'd1;

  // Configuration register indexes
  localparam logic CFG_LUMA_MODE   = 1'b0;
  localparam logic CFG_IMAGE_WIDTH = 1'b1;

  localparam logic [LUMA_MODE_W-1:0]   LUMA_MODE_RST   = 2'd0;
  localparam logic [IMAGE_WIDTH_W-1:0] IMAGE_WIDTH_RST = 13'd640;

  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [3:0] NO_CLASS     = 4'd12;

  // Q16 weights, each set sums to 65536
  localparam logic [15:0] W601_R = 16'd19595;
  localparam logic [15:0] W601_G = 16'd38470;
  localparam logic [15:0] W601_B = 16'd7471;
  localparam logic [15:0] W709_R = 16'd13933;
  localparam logic [15:0] W709_G = 16'd46871;
  localparam logic [15:0] W709_B = 16'd4732;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] code_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       code_used;
    logic       run_end;
  } out_item_t;

  typedef struct packed {
    logic clr;
    logic app;
    logic pix;
    logic decide;
    logic load_glyph;
    logic load_nl;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic nl_pending;
  } dp_sts_t;

  function automatic logic [7:0] level_limit(input logic [3:0] idx);
    logic [7:0] t;
    case (idx)
      4'd0:    t = 8'd234;
      4'd1:    t = 8'd213;
      4'd2:    t = 8'd192;
      4'd3:    t = 8'd171;
      4'd4:    t = 8'd150;
      4'd5:    t = 8'd129;
      4'd6:    t = 8'd108;
      4'd7:    t = 8'd87;
      4'd8:    t = 8'd66;
      4'd9:    t = 8'd45;
      4'd10:   t = 8'd24;
      default: t = 8'd0;
    endcase
    return t;
  endfunction

  // Threshold on the Q16 brightness; squared in RMS mode
  function automatic logic [VAL_W-1:0] level_thresh(input logic [3:0] idx, input logic rms);
    logic [7:0]  t;
    logic [15:0] tt;
    t  = level_limit(idx);
    tt = rms ? 16'(t * t) : {8'd0, t};
    return {tt, 16'd0};
  endfunction

  function automatic logic [7:0] level_glyph(input logic [3:0] lvl);
    logic [7:0] g;
    case (lvl)
      4'd0:    g = "$";
      4'd1:    g = "%";
      4'd2:    g = "W";
      4'd3:    g = "o";
      4'd4:    g = "Z";
      4'd5:    g = "v";
      4'd6:    g = "{";
      4'd7:    g = "1";
      4'd8:    g = "?";
      4'd9:    g = "!";
      4'd10:   g = ":";
      default: g = "'";
    endcase
    return g;
  endfunction

  function automatic logic [3:0] class_of(input logic [7:0] ch);
    logic [3:0] c;
    case (ch)
      "#":      c = 4'd0;
      "[", "]": c = 4'd7;
      "-", "+": c = 4'd8;
      "<", ">": c = 4'd9;
      ",":      c = 4'd10;
      ".":      c = 4'd11;
      default:  c = NO_CLASS;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/aapm_ctrl.sv =====
// Sequencing controller: accepts transactions and steps a pixel through the datapath
module aapm_ctrl
  import aapm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  output logic       in_ready,
  input  dp_sts_t    sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_MUL,
    S_SUM,
    S_DEC,
    S_OUT_GLYPH,
    S_OUT_NL
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    cmd.clr        = accept && (in_func == FUNC_CLEAR);
    cmd.app        = accept && (in_func == FUNC_APPEND);
    cmd.pix        = accept && (in_func == FUNC_PIXEL);
    cmd.decide     = (state_r == S_DEC);
    cmd.load_glyph = (state_r == S_OUT_GLYPH) && sts.out_free;
    cmd.load_nl    = (state_r == S_OUT_NL) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (cmd.pix) state_nxt = S_SQ;
      S_SQ:        state_nxt = S_MUL;
      S_MUL:       state_nxt = S_SUM;
      S_SUM:       state_nxt = S_DEC;
      S_DEC:       state_nxt = S_OUT_GLYPH;
      S_OUT_GLYPH: begin
        if (sts.out_free) state_nxt = sts.nl_pending ? S_OUT_NL : S_IDLE;
      end
      S_OUT_NL:    if (sts.out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/aapm_dp.sv =====
// Datapath: code store, brightness pipeline, level decision and output register
`include "ascii_art_pixel_mapper_with_code_embed_defines.svh"
module aapm_dp
  import aapm_pkg::*;
#(
  parameter int CODE_DEPTH = CODE_DEPTH_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  in_item_t                 in_data,
  input  logic                     cfg_valid,
  input  logic                     cfg_index,
  input  logic [IMAGE_WIDTH_W-1:0] cfg_data,
  input  logic                     out_ready,
  output logic                     out_valid,
  output out_item_t                out_data,
  input  ctrl_cmd_t                cmd,
  output dp_sts_t                  sts
);

  localparam int AW = $clog2(CODE_DEPTH);
  localparam int LW = $clog2(CODE_DEPTH + 1);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (CW > IMAGE_WIDTH_W) ? CW : IMAGE_WIDTH_W;

  // Configuration
  logic [LUMA_MODE_W-1:0]   mode_r;
  logic [IMAGE_WIDTH_W-1:0] width_r;

  // Code store and pointers
  logic [7:0]    code_mem [CODE_DEPTH];
  logic [7:0]    rd_r;
  logic [LW-1:0] code_len_r, code_pos_r;
  logic [CW-1:0] col_r;

  // Brightness pipeline
  logic [7:0]       px_r  [3];
  logic [15:0]      x_r   [3];
  logic [31:0]      prod_r[3];
  logic [15:0]      wgt   [3];
  logic [VAL_W-1:0] val_r;
  logic             rms;

  // Decision
  logic [3:0]    lvl;
  logic          pos_ok, match;
  logic [CW-1:0] cnt_nxt;
  logic [EW-1:0] eff_w;
  logic          nl;
  logic [7:0]    char_r;
  logic          used_r, nl_r;

  logic        out_valid_r;
  out_item_t   out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= LUMA_MODE_RST;
      width_r <= IMAGE_WIDTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LUMA_MODE:   mode_r  <= cfg_data[LUMA_MODE_W-1:0];
        CFG_IMAGE_WIDTH: width_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.app && (code_len_r < LW'(CODE_DEPTH))) begin
      code_mem[code_len_r[AW-1:0]] <= in_data.code_char;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= code_mem[code_pos_r[AW-1:0]];
  end

  // Modes 2 and 3 behave as RMS
  assign rms = (mode_r != MODE_BT601) && (mode_r != MODE_BT709);

  always_comb begin
    if (mode_r == MODE_BT709) begin
      wgt[0] = W709_R;
      wgt[1] = W709_G;
      wgt[2] = W709_B;
    end else begin
      wgt[0] = W601_R;
      wgt[1] = W601_G;
      wgt[2] = W601_B;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix) begin
      px_r[0] <= in_data.red;
      px_r[1] <= in_data.green;
      px_r[2] <= in_data.blue;
    end
    for (int i = 0; i < 3; i++) begin
      x_r[i]    <= rms ? 16'(px_r[i] * px_r[i]) : {8'd0, px_r[i]};
      prod_r[i] <= 32'(wgt[i] * x_r[i]);
    end
    // Weights sum to one in Q16, so the total fits 32 bits
    val_r <= VAL_W'({2'b00, prod_r[0]} + {2'b00, prod_r[1]} + {2'b00, prod_r[2]});
  end

  // Last threshold passed wins; scan from the dimmest end
  always_comb begin
    lvl = 4'd11;
    for (int i = NUM_LIMITS - 1; i >= 0; i--) begin
      if (val_r > level_thresh(4'(i), rms)) lvl = 4'(i);
    end
  end

  assign pos_ok  = (code_pos_r < code_len_r);
  assign match   = pos_ok && (class_of(rd_r) == lvl);
  assign cnt_nxt = col_r + CW'(1);

  always_comb begin
    if (width_r == '0) begin
      eff_w = EW'(1);
    end else if (EW'(width_r) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_r);
    end
  end

  assign nl = (EW'(cnt_nxt) >= eff_w);

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      char_r <= match ? rd_r : level_glyph(lvl);
      used_r <= match;
      nl_r   <= nl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_len_r <= '0;
      code_pos_r <= '0;
      col_r      <= '0;
    end else if (cmd.clr) begin
      code_len_r <= '0;
      code_pos_r <= '0;
      col_r      <= '0;
    end else begin
      if (cmd.app && (code_len_r < LW'(CODE_DEPTH))) begin
        code_len_r <= code_len_r + LW'(1);
      end
      if (cmd.decide) begin
        if (match) code_pos_r <= code_pos_r + LW'(1);
        col_r <= nl ? '0 : cnt_nxt;
      end
    end
  end

  // Output register: holds one result until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_glyph || cmd.load_nl) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_glyph) begin
      out_data_r.out_char  <= char_r;
      out_data_r.code_used <= used_r;
      out_data_r.run_end   <= !nl_r;
    end else if (cmd.load_nl) begin
      out_data_r.out_char  <= NEWLINE_CHAR;
      out_data_r.code_used <= 1'b0;
      out_data_r.run_end   <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.nl_pending = nl_r;

  `AAPM_ASSERT_NOW(a_pos_le_len, clk, rst_n, 1'b1, code_pos_r <= code_len_r, "code position passed code length")
  `AAPM_ASSERT_NOW(a_col_range, clk, rst_n, 1'b1, EW'(col_r) < EW'(MAX_WIDTH), "column count out of range")
  `AAPM_ASSERT_NEXT(a_nl_result, clk, rst_n, cmd.load_nl, out_valid_r && out_data_r.run_end && !out_data_r.code_used && (out_data_r.out_char == NEWLINE_CHAR), "bad newline result")
  `AAPM_ASSERT_NEXT(a_used_class, clk, rst_n, cmd.decide && match, used_r && (class_of(char_r) != NO_CLASS), "emitted code char has no class")

endmodule

// ===== hw/rtl/ascii_art_pixel_mapper_with_code_embed.sv =====
// Top level of the ASCII-art pixel mapper with hidden code embedding
// A pixel transaction is accepted when the block is idle and gives its glyph (or the matching
// code character) after the square, multiply and sum stages of the brightness datapath and
// the decision register, then a newline result at the end of a row; the next transaction is
// taken in the cycle after that last result has entered the output register, so no new pixel
// is accepted before the last one is through. A result still waiting in the output register
// holds the controller until the register frees. Clear and append transactions give no
// result. The code store needs no clearing pass.
module ascii_art_pixel_mapper_with_code_embed
  import aapm_pkg::*;
#(
  parameter int CODE_DEPTH = CODE_DEPTH_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [IMAGE_WIDTH_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  aapm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  aapm_dp #(
    .CODE_DEPTH (CODE_DEPTH),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
